// ===== rtl/bcg_pkg.sv =====
// Shared constants and types for the bilinear corner gradient block.
package bcg_pkg;

  localparam int unsigned ChanW   = 16;
  localparam int unsigned NumChan = 4;
  localparam int unsigned DivSteps = ChanW;
  localparam int unsigned NumW    = 2 * ChanW + 1;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [NumW-1:0]  num_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegWidth   = 3'd0,
    RegHeight  = 3'd1,
    RegTopL    = 3'd2,
    RegTopR    = 3'd3,
    RegBotL    = 3'd4,
    RegBotR    = 3'd5
  } cfg_reg_e;

  function automatic chan_t chan_of(logic [CfgDataW-1:0] word, int unsigned ch);
    chan_t res;
    res = word[CfgDataW-1-ch*ChanW -: ChanW];
    return res;
  endfunction

endpackage

// ===== rtl/bilinear_corner_gradient.sv =====
// Top level of the bilinear four-corner gradient pixel pipeline.
//
//  Channel  Direction  Beat contents
//  in       sink       pos_x_i, pos_y_i
//  out      source     chan_red_o .. chan_alpha_o, coord_outside_o
//  cfg      sink       write enable, register index, 64-bit data
//
// One pixel enters per cycle unless the output stalls. Stages: an input stage,
// a product stage, 16 horizontal divider stages, a product stage, 16 vertical
// divider stages and the output register. The divider stages set the latency.
// Reset empties the pipeline and loads width and height 1 and black corners.
// A stall on the output freezes every stage at once, so no beat is lost.
module bilinear_corner_gradient (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [15:0]               pos_x_i,
  input  logic [15:0]               pos_y_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [15:0]               chan_red_o,
  output logic [15:0]               chan_green_o,
  output logic [15:0]               chan_blue_o,
  output logic [15:0]               chan_alpha_o,
  output logic                      coord_outside_o,
  input  logic                      cfg_we_i,
  input  logic [bcg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bcg_pkg::CfgDataW-1:0] cfg_data_i
);
  import bcg_pkg::*;

  chan_t               width_q, height_q;
  logic [CfgDataW-1:0] tl_q, tr_q, bl_q, br_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= chan_t'(1);
      height_q <= chan_t'(1);
      tl_q     <= '0;
      tr_q     <= '0;
      bl_q     <= '0;
      br_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegWidth:  width_q  <= cfg_data_i[ChanW-1:0];
        RegHeight: height_q <= cfg_data_i[ChanW-1:0];
        RegTopL:   tl_q     <= cfg_data_i;
        RegTopR:   tr_q     <= cfg_data_i;
        RegBotL:   bl_q     <= cfg_data_i;
        RegBotR:   br_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_q;
  assign en          = !out_vld_q || out_ready_i;
  assign in_ready_o  = en;

  // Stage 1: coordinate and weights.
  logic  v1_q, o1_q;
  chan_t x1_q, y1_q, wx1_q, hy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q  <= pos_x_i;
      y1_q  <= pos_y_i;
      wx1_q <= width_q - pos_x_i;
      hy1_q <= height_q - pos_y_i;
      o1_q  <= (pos_x_i >= width_q) || (pos_y_i >= height_q);
    end
  end

  // Stage 2: horizontal numerators.
  logic  v2_q, o2_q;
  chan_t y2_q, hy2_q;
  num_t  nt2_q [NumChan];
  num_t  nb2_q [NumChan];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  for (genvar c = 0; c < NumChan; c++) begin : g_hnum
    logic [2*ChanW-1:0] p_tl, p_tr, p_bl, p_br;
    assign p_tl = chan_of(tl_q, c) * wx1_q;
    assign p_tr = chan_of(tr_q, c) * x1_q;
    assign p_bl = chan_of(bl_q, c) * wx1_q;
    assign p_br = chan_of(br_q, c) * x1_q;
    always_ff @(posedge clk_i) begin
      if (en) begin
        nt2_q[c] <= {1'b0, p_tl} + {1'b0, p_tr};
        nb2_q[c] <= {1'b0, p_bl} + {1'b0, p_br};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      y2_q  <= y1_q;
      hy2_q <= hy1_q;
      o2_q  <= o1_q;
    end
  end

  // Horizontal dividers, with side data delayed alongside.
  chan_t top_q [NumChan];
  chan_t bot_q [NumChan];
  for (genvar c = 0; c < NumChan; c++) begin : g_hdiv
    bcg_div u_top (
      .clk_i (clk_i), .en_i (en), .num_i (nt2_q[c]), .den_i (width_q), .quo_o (top_q[c])
    );
    bcg_div u_bot (
      .clk_i (clk_i), .en_i (en), .num_i (nb2_q[c]), .den_i (width_q), .quo_o (bot_q[c])
    );
  end

  logic [DivSteps-1:0] vh_q;
  logic [DivSteps-1:0] oh_q;
  chan_t               yh_q  [DivSteps];
  chan_t               hyh_q [DivSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vh_q <= '0;
    end else if (en) begin
      vh_q <= {vh_q[DivSteps-2:0], v2_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oh_q <= {oh_q[DivSteps-2:0], o2_q};
      yh_q[0]  <= y2_q;
      hyh_q[0] <= hy2_q;
      for (int i = 1; i < DivSteps; i++) begin
        yh_q[i]  <= yh_q[i-1];
        hyh_q[i] <= hyh_q[i-1];
      end
    end
  end

  // Stage 3: vertical numerators.
  logic v3_q, o3_q;
  num_t nv3_q [NumChan];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= vh_q[DivSteps-1];
    end
  end

  for (genvar c = 0; c < NumChan; c++) begin : g_vnum
    logic [2*ChanW-1:0] p_t, p_b;
    assign p_t = top_q[c] * hyh_q[DivSteps-1];
    assign p_b = bot_q[c] * yh_q[DivSteps-1];
    always_ff @(posedge clk_i) begin
      if (en) begin
        nv3_q[c] <= {1'b0, p_t} + {1'b0, p_b};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o3_q <= oh_q[DivSteps-1];
    end
  end

  // Vertical dividers.
  chan_t val_q [NumChan];
  for (genvar c = 0; c < NumChan; c++) begin : g_vdiv
    bcg_div u_val (
      .clk_i (clk_i), .en_i (en), .num_i (nv3_q[c]), .den_i (height_q), .quo_o (val_q[c])
    );
  end

  logic [DivSteps-1:0] vv_q;
  logic [DivSteps-1:0] ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vv_q <= '0;
    end else if (en) begin
      vv_q <= {vv_q[DivSteps-2:0], v3_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ov_q <= {ov_q[DivSteps-2:0], o3_q};
    end
  end

  // Output register; an outside pixel is forced to zero here.
  chan_t res_q [NumChan];
  logic  outside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vv_q[DivSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      outside_q <= ov_q[DivSteps-1];
      for (int c = 0; c < NumChan; c++) begin
        res_q[c] <= ov_q[DivSteps-1] ? '0 : val_q[c];
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign chan_red_o      = res_q[0];
  assign chan_green_o    = res_q[1];
  assign chan_blue_o     = res_q[2];
  assign chan_alpha_o    = res_q[3];
  assign coord_outside_o = outside_q;

endmodule

// ===== rtl/bcg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module bcg_div (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  bcg_pkg::num_t        num_i,
  input  bcg_pkg::chan_t       den_i,
  output bcg_pkg::chan_t       quo_o
);
  import bcg_pkg::*;

  chan_t rem_q [DivSteps];
  chan_t low_q [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    chan_t              rem_in;
    chan_t              low_in;
    logic [ChanW:0]     trial;
    logic               fits;
    chan_t              rem_d;
    chan_t              low_d;

    if (k == 0) begin : g_first
      // The quotient fits in ChanW bits, so the upper half is already below den.
      assign rem_in = num_i[2*ChanW-1:ChanW];
      assign low_in = num_i[ChanW-1:0];
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
    end

    always_comb begin
      trial = {rem_in, low_in[ChanW-1]};
      fits  = trial >= {1'b0, den_i};
      rem_d = fits ? ChanW'(trial - {1'b0, den_i}) : trial[ChanW-1:0];
      low_d = {low_in[ChanW-2:0], fits};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        low_q[k] <= low_d;
      end
    end
  end

  assign quo_o = low_q[DivSteps-1];

endmodule
